FILE: src/gbk_pkg.sv
// gbk_pkg: shared types and codes for the group-by-key batcher
// no dependencies

package gbk_pkg;

  localparam int LINK_W = 6;
  localparam logic [LINK_W-1:0] LINK_END = 6'd63;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_FLUSH = 2'd1,
    FUNC_RESET = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_MEMBER = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BIN_FULL  = 2'd1,
    ST_NODE_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ADD_WR,
    S_RESP,
    S_FL_HDR,
    S_FL_MEM
  } state_t;

  typedef struct packed {
    logic [15:0]       key;
    logic [15:0]       material;
    logic [LINK_W-1:0] head;
  } bin_entry_t;

  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic [11:0]       item;
    logic [7:0]        sub;
  } node_entry_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [15:0] material;
    logic [11:0] item;
    logic [7:0]  sub;
    logic        last;
  } res_t;

endpackage

FILE: src/group_by_key_batcher_unit.sv
// group_by_key_batcher_unit: top level of the group-by-key batcher
// depends on gbk_pkg, gbk_ctrl (with its two gbk_ram stores) and gbk_outq
//
//   channel  handshake              payload
//   request  req_valid / req_ready  func, group_key, material_tag, item_id, sub_index
//   result   rsp_valid / rsp_ready  kind, status, out_material, out_item, out_sub_index, last
//
// an add searches for its key by reading the bin ram one entry a cycle
// a flush gives one result a cycle from the bin and node rams while the result register has space
// reset and empty flush answer with a single empty result; func 3 is taken and dropped
// sync reset clears the state and the counts only, rams need no clearing pass
// a stalled result channel holds the sequencer; one request is worked on at a time

module group_by_key_batcher_unit #(
  parameter int NODE_COUNT = 32,
  parameter int BIN_COUNT  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  func,
  input  logic [15:0] group_key,
  input  logic [15:0] material_tag,
  input  logic [11:0] item_id,
  input  logic [7:0]  sub_index,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic [15:0] out_material,
  output logic [11:0] out_item,
  output logic [7:0]  out_sub_index,
  output logic        last
);

  logic          push;
  logic          space;
  gbk_pkg::res_t res;

  gbk_ctrl #(.NODE_COUNT(NODE_COUNT), .BIN_COUNT(BIN_COUNT)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .func         (func),
    .group_key    (group_key),
    .material_tag (material_tag),
    .item_id      (item_id),
    .sub_index    (sub_index),
    .space        (space),
    .push         (push),
    .res          (res)
  );

  gbk_outq u_outq (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .res           (res),
    .space         (space),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .kind          (kind),
    .status        (status),
    .out_material  (out_material),
    .out_item      (out_item),
    .out_sub_index (out_sub_index),
    .last          (last)
  );

  a_push_space: assert property (@(posedge clk) disable iff (rst) push |-> space)
    else $error("result pushed into a full output register");

  a_status_add: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && kind != gbk_pkg::KIND_ADD |-> status == gbk_pkg::ST_OK)
    else $error("status set on a non-add result");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (kind == gbk_pkg::KIND_ADD || kind == gbk_pkg::KIND_EMPTY) |-> last)
    else $error("single result without last");

  a_material_hdr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && kind != gbk_pkg::KIND_HEADER |-> out_material == '0)
    else $error("material on a non-header result");

endmodule

FILE: src/gbk_ram.sv
// gbk_ram: generic single write, single read ram with registered read
// no dependencies

module gbk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/gbk_outq.sv
// gbk_outq: result register between the sequencer and the result channel
// depends on gbk_pkg

module gbk_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gbk_pkg::res_t res,
  output logic          space,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output logic [1:0]    kind,
  output logic [1:0]    status,
  output logic [15:0]   out_material,
  output logic [11:0]   out_item,
  output logic [7:0]    out_sub_index,
  output logic          last
);

  logic          valid;
  gbk_pkg::res_t held;

  assign space = !valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (rsp_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= res;
    end
  end

  assign rsp_valid     = valid;
  assign kind          = held.kind;
  assign status        = held.status;
  assign out_material  = held.material;
  assign out_item      = held.item;
  assign out_sub_index = held.sub;
  assign last          = held.last;

endmodule

FILE: src/gbk_ctrl.sv
// gbk_ctrl: sequencer for key lookup, list push and flush walk
// depends on gbk_pkg and gbk_ram (bin store and node store)

module gbk_ctrl #(
  parameter int NODE_COUNT = 32,
  parameter int BIN_COUNT  = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  logic [1:0]    func,
  input  logic [15:0]   group_key,
  input  logic [15:0]   material_tag,
  input  logic [11:0]   item_id,
  input  logic [7:0]    sub_index,
  input  logic          space,
  output logic          push,
  output gbk_pkg::res_t res
);

  localparam int LW  = gbk_pkg::LINK_W;
  localparam int NA  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int BA  = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int NCW = $clog2(NODE_COUNT + 1);
  localparam int BCW = $clog2(BIN_COUNT + 1);
  localparam int BIN_W  = $bits(gbk_pkg::bin_entry_t);
  localparam int NODE_W = $bits(gbk_pkg::node_entry_t);

  gbk_pkg::state_t state, state_next;

  logic [BCW-1:0]    bins_used;
  logic [NCW-1:0]    nodes_used;
  logic [BA-1:0]     idx;
  logic [BA-1:0]     hit;
  logic [LW-1:0]     old_head;
  logic              new_bin;
  gbk_pkg::kind_t    rsp_kind;
  gbk_pkg::status_t  rsp_status;
  logic [15:0]       key;
  logic [15:0]       mat;
  logic [11:0]       item;
  logic [7:0]        sub;

  logic                 bin_we, bin_re, node_we, node_re;
  logic [BA-1:0]        bin_waddr, bin_raddr;
  logic [NA-1:0]        node_waddr, node_raddr;
  gbk_pkg::bin_entry_t  bin_wdata, bin_rd;
  gbk_pkg::node_entry_t node_wdata, node_rd;

  logic nodes_full, bins_full, bins_empty, last_bin, key_hit, head_end, link_end;
  logic accept;

  assign accept     = req_valid && req_ready;
  assign nodes_full = nodes_used >= NCW'(NODE_COUNT);
  assign bins_full  = bins_used >= BCW'(BIN_COUNT);
  assign bins_empty = bins_used == '0;
  assign last_bin   = (BCW'(idx) + BCW'(1)) == bins_used;
  assign key_hit    = bin_rd.key == key;
  assign head_end   = bin_rd.head == gbk_pkg::LINK_END;
  assign link_end   = node_rd.link == gbk_pkg::LINK_END;

  gbk_ram #(.WIDTH(BIN_W), .DEPTH(BIN_COUNT)) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .re    (bin_re),
    .raddr (bin_raddr),
    .rdata (bin_rd)
  );

  gbk_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      gbk_pkg::S_IDLE: begin
        if (req_valid) begin
          unique case (gbk_pkg::func_t'(func))
            gbk_pkg::FUNC_ADD: begin
              if (nodes_full) state_next = gbk_pkg::S_RESP;
              else if (bins_empty) state_next = gbk_pkg::S_ADD_WR;
              else state_next = gbk_pkg::S_SCAN;
            end
            gbk_pkg::FUNC_FLUSH: begin
              state_next = bins_empty ? gbk_pkg::S_RESP : gbk_pkg::S_FL_HDR;
            end
            gbk_pkg::FUNC_RESET: state_next = gbk_pkg::S_RESP;
            default: state_next = gbk_pkg::S_IDLE;
          endcase
        end
      end
      gbk_pkg::S_SCAN: begin
        if (key_hit) state_next = gbk_pkg::S_ADD_WR;
        else if (last_bin) state_next = bins_full ? gbk_pkg::S_RESP : gbk_pkg::S_ADD_WR;
      end
      gbk_pkg::S_ADD_WR: state_next = gbk_pkg::S_RESP;
      gbk_pkg::S_RESP: begin
        if (space) state_next = gbk_pkg::S_IDLE;
      end
      gbk_pkg::S_FL_HDR: begin
        if (space) begin
          if (!head_end) state_next = gbk_pkg::S_FL_MEM;
          else if (last_bin) state_next = gbk_pkg::S_IDLE;
        end
      end
      gbk_pkg::S_FL_MEM: begin
        if (space && link_end) begin
          state_next = last_bin ? gbk_pkg::S_IDLE : gbk_pkg::S_FL_HDR;
        end
      end
      default: state_next = gbk_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready  = 1'b0;
    push       = 1'b0;
    res        = '0;
    bin_we     = 1'b0;
    bin_waddr  = hit;
    bin_wdata  = '{key: key, material: mat, head: LW'(nodes_used)};
    bin_re     = 1'b0;
    bin_raddr  = idx + BA'(1);
    node_we    = 1'b0;
    node_waddr = nodes_used[NA-1:0];
    node_wdata = '{link: old_head, item: item, sub: sub};
    node_re    = 1'b0;
    node_raddr = bin_rd.head[NA-1:0];
    unique case (state)
      gbk_pkg::S_IDLE: begin
        req_ready = 1'b1;
        bin_re    = req_valid;
        bin_raddr = '0;
      end
      gbk_pkg::S_SCAN: begin
        bin_re = 1'b1;
      end
      gbk_pkg::S_ADD_WR: begin
        bin_we  = 1'b1;
        node_we = 1'b1;
      end
      gbk_pkg::S_RESP: begin
        push       = space;
        res.kind   = rsp_kind;
        res.status = rsp_status;
        res.last   = 1'b1;
      end
      gbk_pkg::S_FL_HDR: begin
        push         = space;
        res.kind     = gbk_pkg::KIND_HEADER;
        res.material = bin_rd.material;
        res.last     = last_bin && head_end;
        node_re      = space && !head_end;
        bin_re       = space && head_end;
      end
      gbk_pkg::S_FL_MEM: begin
        push       = space;
        res.kind   = gbk_pkg::KIND_MEMBER;
        res.item   = node_rd.item;
        res.sub    = node_rd.sub;
        res.last   = last_bin && link_end;
        node_re    = space && !link_end;
        node_raddr = node_rd.link[NA-1:0];
        bin_re     = space && link_end;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gbk_pkg::S_IDLE;
      bins_used  <= '0;
      nodes_used <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        gbk_pkg::S_IDLE: begin
          if (accept && gbk_pkg::func_t'(func) == gbk_pkg::FUNC_RESET) begin
            bins_used  <= '0;
            nodes_used <= '0;
          end
        end
        gbk_pkg::S_ADD_WR: begin
          nodes_used <= nodes_used + NCW'(1);
          if (new_bin) bins_used <= bins_used + BCW'(1);
        end
        gbk_pkg::S_FL_HDR: begin
          if (space && head_end && last_bin) begin
            bins_used  <= '0;
            nodes_used <= '0;
          end
        end
        gbk_pkg::S_FL_MEM: begin
          if (space && link_end && last_bin) begin
            bins_used  <= '0;
            nodes_used <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      gbk_pkg::S_IDLE: begin
        if (accept) begin
          key        <= group_key;
          mat        <= material_tag;
          item       <= item_id;
          sub        <= sub_index;
          idx        <= '0;
          hit        <= '0;
          old_head   <= gbk_pkg::LINK_END;
          new_bin    <= 1'b1;
          rsp_status <= (gbk_pkg::func_t'(func) == gbk_pkg::FUNC_ADD && nodes_full) ?
                        gbk_pkg::ST_NODE_FULL : gbk_pkg::ST_OK;
          rsp_kind   <= (gbk_pkg::func_t'(func) == gbk_pkg::FUNC_ADD) ?
                        gbk_pkg::KIND_ADD : gbk_pkg::KIND_EMPTY;
        end
      end
      gbk_pkg::S_SCAN: begin
        if (key_hit) begin
          hit      <= idx;
          old_head <= bin_rd.head;
          new_bin  <= 1'b0;
        end else if (last_bin) begin
          if (bins_full) rsp_status <= gbk_pkg::ST_BIN_FULL;
          hit      <= bins_used[BA-1:0];
          old_head <= gbk_pkg::LINK_END;
          new_bin  <= 1'b1;
        end else begin
          idx <= idx + BA'(1);
        end
      end
      gbk_pkg::S_FL_HDR: begin
        if (space && head_end) idx <= idx + BA'(1);
      end
      gbk_pkg::S_FL_MEM: begin
        if (space && link_end) idx <= idx + BA'(1);
      end
      default: ;
    endcase
  end

endmodule

FILE: tb/sv/group_by_key_batcher_unit_tb.sv
// group_by_key_batcher_unit_tb: self-checking bench for the group-by-key batcher
// keeps its own model of the bin and node stores and checks every result transfer in order
// depends on gbk_pkg and group_by_key_batcher_unit

module group_by_key_batcher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = 32;
  localparam int BINS = 32;
  localparam int MAX_RESULTS = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 20;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  logic [1:0]  func;
  logic [15:0] group_key;
  logic [15:0] material_tag;
  logic [11:0] item_id;
  logic [7:0]  sub_index;
  logic        rsp_valid;
  logic        rsp_ready;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [15:0] out_material;
  logic [11:0] out_item;
  logic [7:0]  out_sub_index;
  logic        last;

  group_by_key_batcher_unit u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .func(func),
    .group_key(group_key),
    .material_tag(material_tag),
    .item_id(item_id),
    .sub_index(sub_index),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .kind(kind),
    .status(status),
    .out_material(out_material),
    .out_item(out_item),
    .out_sub_index(out_sub_index),
    .last(last)
  );

  // model of the stores
  logic [15:0]                grp_key[BINS];
  logic [15:0]                grp_mat[BINS];
  logic [gbk_pkg::LINK_W-1:0] grp_head[BINS];
  logic [gbk_pkg::LINK_W-1:0] node_next[NODES];
  logic [11:0]                node_item[NODES];
  logic [7:0]                 node_sub[NODES];
  int                         grp_count;
  int                         node_count;

  gbk_pkg::res_t pending_results[$];

  int cycles;
  int errors;
  int items_sent;
  int results_seen;
  int adds_ok;
  int adds_refused;
  int flushes;
  int members_seen;
  int hold_cycles;
  int stall_left;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("group_by_key_batcher_unit: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("error at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic gbk_pkg::res_t make_res(input gbk_pkg::kind_t k,
                                             input gbk_pkg::status_t s,
                                             input logic [15:0] m, input logic [11:0] it,
                                             input logic [7:0] sb);
    gbk_pkg::res_t r;
    r.kind = k;
    r.status = s;
    r.material = m;
    r.item = it;
    r.sub = sb;
    r.last = 1'b0;
    return r;
  endfunction

  // works out the results of one accepted request and updates the model stores
  function automatic void compute_groups(input gbk_pkg::func_t f, input logic [15:0] k,
                                         input logic [15:0] m, input logic [11:0] it,
                                         input logic [7:0] sb);
    int b;
    int cur;
    int steps;
    int emitted;
    bit found;
    found = 1'b0;
    case (f)
      gbk_pkg::FUNC_ADD: begin
        if (node_count >= NODES) begin
          pending_results.push_back(make_res(gbk_pkg::KIND_ADD, gbk_pkg::ST_NODE_FULL,
                                             '0, '0, '0));
          adds_refused++;
        end else begin
          for (b = 0; b < grp_count; b++) begin
            if (grp_key[b] == k) begin
              found = 1'b1;
              break;
            end
          end
          if (!found && grp_count >= BINS) begin
            pending_results.push_back(make_res(gbk_pkg::KIND_ADD, gbk_pkg::ST_BIN_FULL,
                                               '0, '0, '0));
            adds_refused++;
          end else begin
            if (!found) begin
              b = grp_count;
              grp_head[b] = gbk_pkg::LINK_END;
              grp_count++;
            end
            node_item[node_count] = it;
            node_sub[node_count] = sb;
            node_next[node_count] = grp_head[b];
            grp_head[b] = gbk_pkg::LINK_W'(node_count);
            node_count++;
            grp_mat[b] = m;
            grp_key[b] = k;
            pending_results.push_back(make_res(gbk_pkg::KIND_ADD, gbk_pkg::ST_OK,
                                               '0, '0, '0));
            adds_ok++;
          end
        end
        pending_results[pending_results.size()-1].last = 1'b1;
      end
      gbk_pkg::FUNC_FLUSH: begin
        flushes++;
        if (grp_count == 0) begin
          pending_results.push_back(make_res(gbk_pkg::KIND_EMPTY, gbk_pkg::ST_OK,
                                             '0, '0, '0));
        end else begin
          emitted = 0;
          for (b = 0; b < grp_count && emitted < MAX_RESULTS; b++) begin
            pending_results.push_back(make_res(gbk_pkg::KIND_HEADER, gbk_pkg::ST_OK,
                                               grp_mat[b], '0, '0));
            emitted++;
            cur = grp_head[b];
            steps = 0;
            while (cur != gbk_pkg::LINK_END && cur < node_count && steps < NODES &&
                   emitted < MAX_RESULTS) begin
              pending_results.push_back(make_res(gbk_pkg::KIND_MEMBER, gbk_pkg::ST_OK,
                                                 '0, node_item[cur], node_sub[cur]));
              emitted++;
              cur = node_next[cur];
              steps++;
            end
          end
          grp_count = 0;
          node_count = 0;
        end
        pending_results[pending_results.size()-1].last = 1'b1;
      end
      gbk_pkg::FUNC_RESET: begin
        grp_count = 0;
        node_count = 0;
        pending_results.push_back(make_res(gbk_pkg::KIND_EMPTY, gbk_pkg::ST_OK,
                                           '0, '0, '0));
        pending_results[pending_results.size()-1].last = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // called at a rising edge; returns at the edge of the transfer or after the gap
  task automatic send_request(input gbk_pkg::func_t f, input logic [15:0] k,
                              input logic [15:0] m, input logic [11:0] it,
                              input logic [7:0] sb);
    int gap;
    func <= f;
    group_key <= k;
    material_tag <= m;
    item_id <= it;
    sub_index <= sb;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    compute_groups(f, k, m, it, sb);
    items_sent++;
    gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : pick_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s expected %0h got %0h", results_seen, name,
                                want, got));
  endtask

  task automatic check_result();
    gbk_pkg::res_t e;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending, kind %0d", kind));
    end else begin
      e = pending_results.pop_front();
      check_field("kind", 16'(e.kind), 16'(kind));
      check_field("status", 16'(e.status), 16'(status));
      check_field("material", e.material, out_material);
      check_field("item", 16'(e.item), 16'(out_item));
      check_field("sub_index", 16'(e.sub), 16'(out_sub_index));
      check_field("last", 16'(e.last), 16'(last));
      if (e.kind == gbk_pkg::KIND_MEMBER) members_seen++;
    end
    results_seen++;
  endtask

  // result side: checks each transfer, then picks the next ready level
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) check_result();
    if (hold_cycles > 0) begin
      hold_cycles--;
      rsp_ready <= 1'b0;
    end else if (no_gaps) begin
      rsp_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 65) begin
      rsp_ready <= 1'b1;
    end else begin
      stall_left = pick_len() - 1;
      rsp_ready <= 1'b0;
    end
  end

  task automatic test_empty_store();
    send_request(gbk_pkg::FUNC_FLUSH, 16'h0000, 16'h0000, 12'h000, 8'h00);
    send_request(gbk_pkg::FUNC_RESET, 16'hffff, 16'hffff, 12'hfff, 8'hff);
    send_request(gbk_pkg::FUNC_NONE, 16'ha5a5, 16'h5a5a, 12'ha5a, 8'h5a);
    send_request(gbk_pkg::FUNC_FLUSH, 16'h1234, 16'h4321, 12'h123, 8'h12);
  endtask

  task automatic test_field_extremes();
    send_request(gbk_pkg::FUNC_ADD, 16'h0000, 16'h0000, 12'h000, 8'h00);
    send_request(gbk_pkg::FUNC_ADD, 16'hffff, 16'hffff, 12'hfff, 8'hff);
    // same key again: pushed to the front, material overwritten
    send_request(gbk_pkg::FUNC_ADD, 16'h0000, 16'h1234, 12'h555, 8'haa);
    send_request(gbk_pkg::FUNC_NONE, 16'h0000, 16'hffff, 12'hfff, 8'hff);
    send_request(gbk_pkg::FUNC_ADD, 16'hffff, 16'h0001, 12'h001, 8'h01);
    send_request(gbk_pkg::FUNC_ADD, 16'h8000, 16'h8000, 12'h800, 8'h80);
    send_request(gbk_pkg::FUNC_FLUSH, 16'h0000, 16'h0000, 12'h000, 8'h00);
    send_request(gbk_pkg::FUNC_ADD, 16'h7fff, 16'h7fff, 12'h7ff, 8'h7f);
    // reset of a non-empty store, then a flush must find it empty
    send_request(gbk_pkg::FUNC_RESET, 16'h0000, 16'h0000, 12'h000, 8'h00);
    send_request(gbk_pkg::FUNC_FLUSH, 16'h0000, 16'h0000, 12'h000, 8'h00);
  endtask

  // long receiver hold-off while the store fills to its limit, then the largest flush
  task automatic test_full_store_backpressure();
    int i;
    wait_drained();
    hold_cycles = 400;
    for (i = 0; i < NODES; i++)
      send_request(gbk_pkg::FUNC_ADD, 16'($urandom), 16'($urandom), 12'($urandom),
                   8'($urandom));
    send_request(gbk_pkg::FUNC_ADD, 16'($urandom), 16'hbeef, 12'h321, 8'h11);
    send_request(gbk_pkg::FUNC_ADD, 16'($urandom), 16'hcafe, 12'h654, 8'h22);
    send_request(gbk_pkg::FUNC_FLUSH, 16'h0000, 16'h0000, 12'h000, 8'h00);
    wait_drained();
    // full again with few keys, refused, then cleared by reset
    for (i = 0; i < NODES + 1; i++)
      send_request(gbk_pkg::FUNC_ADD, 16'($urandom_range(0, 2)), 16'($urandom),
                   12'($urandom), 8'($urandom));
    send_request(gbk_pkg::FUNC_RESET, 16'h0000, 16'h0000, 12'h000, 8'h00);
    send_request(gbk_pkg::FUNC_FLUSH, 16'h0000, 16'h0000, 12'h000, 8'h00);
  endtask

  task automatic test_random_batches();
    int stop_at;
    int r;
    int n;
    int pool_n;
    int i;
    logic [15:0] pool[8];
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      no_gaps = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_request(gbk_pkg::func_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                     12'($urandom), 8'($urandom));
      end else if (r < 12) begin
        n = NODES + $urandom_range(1, 3) - node_count;
        for (i = 0; i < n; i++)
          send_request(gbk_pkg::FUNC_ADD, 16'($urandom_range(0, 40)), 16'($urandom),
                       12'($urandom), 8'($urandom));
        send_request(gbk_pkg::FUNC_FLUSH, 16'($urandom), 16'($urandom), 12'($urandom),
                     8'($urandom));
      end else begin
        pool_n = $urandom_range(1, 6);
        for (i = 0; i < pool_n; i++) pool[i] = 16'($urandom);
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++)
          send_request(gbk_pkg::FUNC_ADD, pool[$urandom_range(0, pool_n - 1)],
                       16'($urandom), 12'($urandom), 8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 80)
          send_request(gbk_pkg::FUNC_FLUSH, 16'($urandom), 16'($urandom), 12'($urandom),
                       8'($urandom));
        else if (r < 90)
          send_request(gbk_pkg::FUNC_RESET, 16'($urandom), 16'($urandom), 12'($urandom),
                       8'($urandom));
      end
    end
    no_gaps = 1'b0;
    send_request(gbk_pkg::FUNC_FLUSH, 16'h0000, 16'h0000, 12'h000, 8'h00);
  endtask

  initial begin
    cycles = 0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    adds_ok = 0;
    adds_refused = 0;
    flushes = 0;
    members_seen = 0;
    hold_cycles = 0;
    stall_left = 0;
    no_gaps = 1'b0;
    grp_count = 0;
    node_count = 0;
    rst <= 1'b1;
    req_valid <= 1'b0;
    rsp_ready <= 1'b0;
    func <= gbk_pkg::FUNC_NONE;
    group_key <= '0;
    material_tag <= '0;
    item_id <= '0;
    sub_index <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_store();
    test_field_extremes();
    test_full_store_backpressure();
    test_random_batches();

    wait_drained();
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("sent %0d requests: %0d adds stored, %0d refused, %0d flushes", items_sent,
             adds_ok, adds_refused, flushes);
    $display("checked %0d results including %0d group members, %0d errors", results_seen,
             members_seen, errors);
    if (errors == 0) begin
      $display("group_by_key_batcher_unit: match");
    end else begin
      $display("group_by_key_batcher_unit: mismatch");
    end
    $finish;
  end

endmodule
